// File: hw/rtl/assert_macros.svh
// Assertion helpers for the segment intersection block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked while reset is released
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while reset is released
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/segi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package segi_pkg;
	localparam int CW   = 16;           // coordinate width
	localparam int DW   = CW + 1;       // coordinate difference width
	localparam int PW   = 2 * DW;       // product of two differences
	localparam int XW   = PW + 1;       // cross product width
	localparam int NW   = XW + DW;      // numerator width
	localparam int QW   = DW;           // quotient bits, one per cell
	localparam int DPAD = NW - (XW - 1) - (QW - 1);
	localparam int LAT  = 5 + QW + 1;   // start to strobe, in cycles

	typedef struct packed {
		logic          valid;
		logic          hit;
		logic          neg_x;
		logic          neg_y;
		logic [CW-1:0] a0_x;
		logic [CW-1:0] a0_y;
	} segi_meta_t;
endpackage
`default_nettype wire

// File: hw/rtl/segment_intersection_top.sv
// Segment intersection: tests segment a0-a1 against b0-b1 (signed Q12.4)
// and gives the crossing point.
// Request channel: drive the eight coordinates and pulse start; a request is
// taken at each rising edge with start high and busy low. busy is always
// low, so a new request may be issued every cycle.
// Result channel: strobe is high for one cycle with hit, cross_x and
// cross_y. cross_x and cross_y are zero on a miss. Results leave in request
// order, one per cycle at full rate.
// Pipeline: front stages of difference, multiply and range test, then a row
// of 17 restoring divider cells (one quotient bit each, both axes at once),
// then the output register.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears all valid flags and the strobe; requests in flight are lost.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module segment_intersection_top import segi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [CW-1:0] a0_x,
	input  wire logic signed [CW-1:0] a0_y,
	input  wire logic signed [CW-1:0] a1_x,
	input  wire logic signed [CW-1:0] a1_y,
	input  wire logic signed [CW-1:0] b0_x,
	input  wire logic signed [CW-1:0] b0_y,
	input  wire logic signed [CW-1:0] b1_x,
	input  wire logic signed [CW-1:0] b1_y,
	output logic                      strobe,
	output logic                      hit,
	output logic signed [CW-1:0]      cross_x,
	output logic signed [CW-1:0]      cross_y
);
	segi_meta_t    meta_c [QW+1];
	logic [NW-1:0] rx_c [QW+1];
	logic [NW-1:0] ry_c [QW+1];
	logic [QW-1:0] qx_c [QW+1];
	logic [QW-1:0] qy_c [QW+1];
	logic [NW-1:0] ds_c [QW+1];
	segi_meta_t    mo;
	logic signed [CW+1:0] sqx, sqy, px, py;

	assign busy = 1'b0;

	segi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.a0_x   (a0_x),
		.a0_y   (a0_y),
		.a1_x   (a1_x),
		.a1_y   (a1_y),
		.b0_x   (b0_x),
		.b0_y   (b0_y),
		.b1_x   (b1_x),
		.b1_y   (b1_y),
		.meta   (meta_c[0]),
		.num_x  (rx_c[0]),
		.num_y  (ry_c[0]),
		.dsh    (ds_c[0])
	);
	assign qx_c[0] = '0;
	assign qy_c[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		segi_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.meta_in  (meta_c[i]),
			.rem_x_in (rx_c[i]),
			.rem_y_in (ry_c[i]),
			.q_x_in   (qx_c[i]),
			.q_y_in   (qy_c[i]),
			.dsh_in   (ds_c[i]),
			.meta_q   (meta_c[i+1]),
			.rem_x_q  (rx_c[i+1]),
			.rem_y_q  (ry_c[i+1]),
			.q_x_q    (qx_c[i+1]),
			.q_y_q    (qy_c[i+1]),
			.dsh_q    (ds_c[i+1])
		);
	end

	always_comb begin
		mo  = meta_c[QW];
		sqx = mo.neg_x ? -$signed({1'b0, qx_c[QW]}) : $signed({1'b0, qx_c[QW]});
		sqy = mo.neg_y ? -$signed({1'b0, qy_c[QW]}) : $signed({1'b0, qy_c[QW]});
		px  = $signed({mo.a0_x[CW-1], mo.a0_x[CW-1], mo.a0_x}) + sqx;
		py  = $signed({mo.a0_y[CW-1], mo.a0_y[CW-1], mo.a0_y}) + sqy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe  <= 1'b0;
			hit     <= 1'b0;
			cross_x <= '0;
			cross_y <= '0;
		end else begin
			strobe  <= mo.valid;
			hit     <= mo.valid && mo.hit;
			cross_x <= mo.hit ? px[CW-1:0] : '0;
			cross_y <= mo.hit ? py[CW-1:0] : '0;
		end
	end

	`ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##LAT strobe, "request lost in pipeline")
	`ASSERT_IMP(a_no_extra, clk, arst_n, strobe, $past(start, LAT), "result without request")
	`ASSERT_IMP(a_miss_zero, clk, arst_n, strobe && !hit, cross_x == '0 && cross_y == '0, "miss with nonzero point")
	`ASSERT_NEXT(a_idle_quiet, clk, arst_n, !mo.valid, !strobe && !hit, "strobe without valid")
endmodule
`default_nettype wire

// File: hw/rtl/segi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module segi_front import segi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [CW-1:0] a0_x,
	input  wire logic signed [CW-1:0] a0_y,
	input  wire logic signed [CW-1:0] a1_x,
	input  wire logic signed [CW-1:0] a1_y,
	input  wire logic signed [CW-1:0] b0_x,
	input  wire logic signed [CW-1:0] b0_y,
	input  wire logic signed [CW-1:0] b1_x,
	input  wire logic signed [CW-1:0] b1_y,
	output segi_meta_t                meta,
	output logic [NW-1:0]             num_x,
	output logic [NW-1:0]             num_y,
	output logic [NW-1:0]             dsh
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, d0x_s1, d0y_s1;
	logic [CW-1:0] a0x_s1, a0y_s1, a0x_s2, a0y_s2, a0x_s3, a0y_s3, a0x_s4, a0y_s4;
	logic [CW-1:0] a0x_s5, a0y_s5;
	logic signed [PW-1:0] md1_s2, md2_s2, ms1_s2, ms2_s2, mt1_s2, mt2_s2;
	logic signed [DW-1:0] dax_s2, day_s2, dax_s3, day_s3;
	logic signed [XW-1:0] den_s3, sn_s3, tn_s3, den_s4;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic hit_s4, hit_s5, negx_s5, negy_s5;
	logic [NW-1:0] magx_s5, magy_s5;
	logic [XW-2:0] magd_s5;
	logic pos, hit_c;
	logic [XW-1:0] den_abs;

	always_comb begin
		pos = !den_s3[XW-1];
		hit_c = (den_s3 != '0) && (sn_s3[XW-1] != pos) && (tn_s3[XW-1] != pos)
			&& ((sn_s3 > den_s3) != pos) && ((tn_s3 > den_s3) != pos);
		den_abs = den_s4[XW-1] ? XW'(-den_s4) : XW'(den_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		dax_s1 <= DW'(a1_x) - DW'(a0_x);
		day_s1 <= DW'(a1_y) - DW'(a0_y);
		dbx_s1 <= DW'(b1_x) - DW'(b0_x);
		dby_s1 <= DW'(b1_y) - DW'(b0_y);
		d0x_s1 <= DW'(a0_x) - DW'(b0_x);
		d0y_s1 <= DW'(a0_y) - DW'(b0_y);
		a0x_s1 <= a0_x;
		a0y_s1 <= a0_y;

		md1_s2 <= dax_s1 * dby_s1;
		md2_s2 <= dbx_s1 * day_s1;
		ms1_s2 <= dax_s1 * d0y_s1;
		ms2_s2 <= day_s1 * d0x_s1;
		mt1_s2 <= dbx_s1 * d0y_s1;
		mt2_s2 <= dby_s1 * d0x_s1;
		dax_s2 <= dax_s1;
		day_s2 <= day_s1;
		a0x_s2 <= a0x_s1;
		a0y_s2 <= a0y_s1;

		den_s3 <= XW'(md1_s2) - XW'(md2_s2);
		sn_s3  <= XW'(ms1_s2) - XW'(ms2_s2);
		tn_s3  <= XW'(mt1_s2) - XW'(mt2_s2);
		dax_s3 <= dax_s2;
		day_s3 <= day_s2;
		a0x_s3 <= a0x_s2;
		a0y_s3 <= a0y_s2;

		hit_s4 <= hit_c;
		nx_s4  <= tn_s3 * dax_s3;
		ny_s4  <= tn_s3 * day_s3;
		den_s4 <= den_s3;
		a0x_s4 <= a0x_s3;
		a0y_s4 <= a0y_s3;

		// divide magnitudes; sign applied after the last cell
		hit_s5  <= hit_s4;
		magx_s5 <= nx_s4[NW-1] ? NW'(-nx_s4) : NW'(nx_s4);
		magy_s5 <= ny_s4[NW-1] ? NW'(-ny_s4) : NW'(ny_s4);
		magd_s5 <= den_abs[XW-2:0];
		negx_s5 <= nx_s4[NW-1] ^ den_s4[XW-1];
		negy_s5 <= ny_s4[NW-1] ^ den_s4[XW-1];
		a0x_s5  <= a0x_s4;
		a0y_s5  <= a0y_s4;
	end

	always_comb begin
		meta.valid = v_s5;
		meta.hit   = hit_s5;
		meta.neg_x = negx_s5;
		meta.neg_y = negy_s5;
		meta.a0_x  = a0x_s5;
		meta.a0_y  = a0y_s5;
		num_x = magx_s5;
		num_y = magy_s5;
		dsh   = {{DPAD{1'b0}}, magd_s5, {(QW-1){1'b0}}};
	end
endmodule
`default_nettype wire

// File: hw/rtl/segi_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module segi_div_cell import segi_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  segi_meta_t         meta_in,
	input  wire logic [NW-1:0] rem_x_in,
	input  wire logic [NW-1:0] rem_y_in,
	input  wire logic [QW-1:0] q_x_in,
	input  wire logic [QW-1:0] q_y_in,
	input  wire logic [NW-1:0] dsh_in,
	output segi_meta_t         meta_q,
	output logic [NW-1:0]      rem_x_q,
	output logic [NW-1:0]      rem_y_q,
	output logic [QW-1:0]      q_x_q,
	output logic [QW-1:0]      q_y_q,
	output logic [NW-1:0]      dsh_q
);
	logic ge_x, ge_y;

	assign ge_x = rem_x_in >= dsh_in;
	assign ge_y = rem_y_in >= dsh_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_q <= '0;
		end else begin
			meta_q <= meta_in;
		end
	end

	// one restoring step per axis; halve the divisor for the next cell
	always_ff @(posedge clk) begin
		rem_x_q <= ge_x ? rem_x_in - dsh_in : rem_x_in;
		rem_y_q <= ge_y ? rem_y_in - dsh_in : rem_y_in;
		q_x_q   <= {q_x_in[QW-2:0], ge_x};
		q_y_q   <= {q_y_in[QW-2:0], ge_y};
		dsh_q   <= dsh_in >> 1;
	end
endmodule
`default_nettype wire

// File: sim/segment_intersection_checker.sv
`timescale 1ns / 1ps
module segment_intersection_checker import segi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic signed [CW-1:0] a0_x,
	input  logic signed [CW-1:0] a0_y,
	input  logic signed [CW-1:0] a1_x,
	input  logic signed [CW-1:0] a1_y,
	input  logic signed [CW-1:0] b0_x,
	input  logic signed [CW-1:0] b0_y,
	input  logic signed [CW-1:0] b1_x,
	input  logic signed [CW-1:0] b1_y,
	input  logic                 strobe,
	input  logic                 hit,
	input  logic signed [CW-1:0] cross_x,
	input  logic signed [CW-1:0] cross_y,
	output int                   errors,
	output int                   pending
);
	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} crossing_t;

	crossing_t crossings_due[$];

	// Exact integer intersection test; 64-bit math holds every product.
	function automatic crossing_t predict_crossing(
		input logic signed [CW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y
	);
		longint dax, day, dbx, dby, d0x, d0y, den, sn, tn, qx, qy;
		crossing_t r;
		r = '0;
		dax = p1x - p0x;
		day = p1y - p0y;
		dbx = p3x - p2x;
		dby = p3y - p2y;
		d0x = p0x - p2x;
		d0y = p0y - p2y;
		den = dax * dby - dbx * day;
		sn = dax * d0y - day * d0x;
		tn = dbx * d0y - dby * d0x;
		if (den == 0)
			return r;
		if (den > 0) begin
			if (sn < 0 || tn < 0 || sn > den || tn > den)
				return r;
		end else begin
			if (sn >= 0 || tn >= 0 || sn <= den || tn <= den)
				return r;
		end
		// SystemVerilog integer division truncates toward zero
		qx = (tn * dax) / den;
		qy = (tn * day) / den;
		r.hit = 1'b1;
		r.x = CW'(p0x + qx);
		r.y = CW'(p0y + qy);
		return r;
	endfunction

	assign pending = crossings_due.size();

	always @(posedge clk or negedge arst_n) begin
		crossing_t want;
		if (!arst_n) begin
			errors <= 0;
			crossings_due.delete();
		end else begin
			if (start && !busy)
				crossings_due.push_back(predict_crossing(a0_x, a0_y, a1_x, a1_y,
					b0_x, b0_y, b1_x, b1_y));
			if (strobe) begin
				if (crossings_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected result hit=%0b x=%0d y=%0d",
							hit, cross_x, cross_y);
					errors <= errors + 1;
				end else begin
					want = crossings_due.pop_front();
					if (want.hit !== hit || want.x !== cross_x || want.y !== cross_y) begin
						if (errors < 10)
							$display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
								want.hit, want.x, want.y, hit, cross_x, cross_y);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// File: sim/segment_intersection_top_tb.sv
`timescale 1ns / 1ps
module segment_intersection_top_tb import segi_pkg::*; ();
	localparam int STALL_LIMIT = 4000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic signed [CW-1:0] a0_x = '0, a0_y = '0, a1_x = '0, a1_y = '0;
	logic signed [CW-1:0] b0_x = '0, b0_y = '0, b1_x = '0, b1_y = '0;
	logic                 strobe, hit;
	logic signed [CW-1:0] cross_x, cross_y;
	int                   errors, pending;
	int                   quiet_cycles = 0;
	int                   idle_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_intersection_top u_top (.*);

	segment_intersection_checker u_chk (.*);

	// Count cycles with no request or result moving.
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("segment_intersection_top regression: fail");
			$finish;
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1: return CW'($urandom_range(0, 64) - 32);
			2: return CW'($urandom_range(0, 2048) - 1024);
			default: return CW'($urandom);
		endcase
	endfunction

	// Issue one request, holding idle cycles first according to idle_pct.
	task automatic send_pair(input logic signed [CW-1:0] p0x, p0y, p1x, p1y,
		p2x, p2y, p3x, p3y);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{a0_x, a0_y, a1_x, a1_y} <= {p0x, p0y, p1x, p1y};
		{b0_x, b0_y, b1_x, b1_y} <= {p2x, p2y, p3x, p3y};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Mostly segments aimed to cross or touch: B starts at A's first end or runs from or across A's midpoint.
	task automatic send_random();
		logic signed [CW-1:0] p0x, p0y, p1x, p1y, mx, my;
		p0x = rand_coord();
		p0y = rand_coord();
		p1x = rand_coord();
		p1y = rand_coord();
		if ($urandom_range(0, 3) == 0) begin
			send_pair(p0x, p0y, p1x, p1y, rand_coord(), rand_coord(),
				rand_coord(), rand_coord());
		end else begin
			mx = CW'((32'(p0x) + 32'(p1x)) >>> 1);
			my = CW'((32'(p0y) + 32'(p1y)) >>> 1);
			case ($urandom_range(0, 3))
				0: send_pair(p0x, p0y, p1x, p1y, p0x, p0y, rand_coord(), rand_coord());
				1: send_pair(p0x, p0y, p1x, p1y, mx, my, p0x, p1y);
				default: send_pair(p0x, p0y, p1x, p1y,
					CW'(mx - $urandom_range(0, 255)), CW'(my + $urandom_range(0, 255)),
					CW'(mx + $urandom_range(0, 255)), CW'(my - $urandom_range(0, 255)));
			endcase
		end
	endtask

	initial begin
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// crossing, positive and negative denominator
		send_pair(0, 0, 160, 160, 0, 160, 160, 0);
		send_pair(0, 0, 160, 160, 160, 0, 0, 160);
		// shared endpoint, both orientations
		send_pair(0, 0, 160, 0, 160, 0, 160, 160);
		send_pair(0, 0, 160, 0, 160, 160, 160, 0);
		send_pair(0, 0, 160, 160, 16, 16, 64, 64);
		send_pair(0, 0, 160, 0, 0, 16, 160, 16);
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 16, 16, 100, 0, 100, 50);
		send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
		send_pair(0, 0, 3, 7, 0, 5, 7, 0);
		send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				1: idle_pct = 83;
				3: idle_pct = 37;
				default: idle_pct = 0;
			endcase
			repeat (387) send_random();
		end
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (LAT + 5) @(posedge clk);
		if (errors == 0)
			$display("segment_intersection_top regression: pass");
		else
			$display("segment_intersection_top regression: fail");
		$finish;
	end
endmodule
